FILE: rtl/wpd_pkg.sv
// Shared constants, payload types and helper functions for the waveform peak decimator.
package wpd_pkg;

    // Frame and sample geometry.
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RUN_DEF = 64;

    // Widths of the configuration registers and of the bin bookkeeping.
    localparam int CH_BITS = 4;
    localparam int FRAME_BITS = 24;
    localparam int BIN_BITS = 16;
    localparam int BOUND_BITS = FRAME_BITS + BIN_BITS;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_INDEX_BITS = 2;

    // A channel sum holds up to MAX_CHANNELS magnitudes of 2**(SAMPLE_BITS-1).
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    localparam int PEAK_BITS = 16;

    // Exact division by the channel count: floor(x / d) == (x * ceil(2**K / d)) >> K
    // for every x below 2**SUM_BITS when K = SUM_BITS + ceil(log2(d)).
    localparam int RECIP_SHIFT = SUM_BITS + $clog2(MAX_CHANNELS);
    localparam int RECIP_BITS = RECIP_SHIFT + 1;
    localparam logic [RECIP_BITS-1:0] ONE_K = RECIP_BITS'(1) << RECIP_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP_1 = ONE_K;
    localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'((ONE_K + 1) / 2);
    localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'((ONE_K + 2) / 3);
    localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((ONE_K + 3) / 4);
    localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'((ONE_K + 4) / 5);
    localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((ONE_K + 5) / 6);
    localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'((ONE_K + 6) / 7);
    localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'((ONE_K + 7) / 8);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_TOTAL_FRAMES  = 2'd1,
        CFG_TARGET_BINS   = 2'd2
    } t_cfg_index;

    // One input word: one audio frame.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ch0_sample;
        logic signed [SAMPLE_BITS-1:0] ch1_sample;
        logic signed [SAMPLE_BITS-1:0] ch2_sample;
        logic signed [SAMPLE_BITS-1:0] ch3_sample;
        logic signed [SAMPLE_BITS-1:0] ch4_sample;
        logic signed [SAMPLE_BITS-1:0] ch5_sample;
        logic signed [SAMPLE_BITS-1:0] ch6_sample;
        logic signed [SAMPLE_BITS-1:0] ch7_sample;
    } t_frame;

    // One output word: the peak of one bin.
    typedef struct packed {
        logic [PEAK_BITS-1:0] bin_peak;
        logic [BIN_BITS-1:0]  bin_number;
        logic                 run_end;
        logic                 block_end;
    } t_result;

    // Channel count clamped to 1..MAX_CHANNELS.
    function automatic logic [CH_BITS-1:0] eff_channels(input logic [CH_BITS-1:0] c);
        logic [CH_BITS-1:0] r;
        r = c;
        if (c == '0) begin
            r = CH_BITS'(1);
        end else if (c > CH_BITS'(MAX_CHANNELS)) begin
            r = CH_BITS'(MAX_CHANNELS);
        end
        return r;
    endfunction

    // Reciprocal of an effective channel count.
    function automatic logic [RECIP_BITS-1:0] recip(input logic [CH_BITS-1:0] c);
        logic [RECIP_BITS-1:0] r;
        case (c)
            CH_BITS'(2): r = RECIP_2;
            CH_BITS'(3): r = RECIP_3;
            CH_BITS'(4): r = RECIP_4;
            CH_BITS'(5): r = RECIP_5;
            CH_BITS'(6): r = RECIP_6;
            CH_BITS'(7): r = RECIP_7;
            CH_BITS'(8): r = RECIP_8;
            default:     r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/wpd_lane.sv
// One channel lane: captures the magnitude of its sample, or zero when the channel is unused.
module wpd_lane
    import wpd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_enable,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic        [SAMPLE_BITS-1:0] o_mag
);

    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;

    // Two's complement magnitude; the most negative code maps to 2**(SAMPLE_BITS-1).
    assign raw = SAMPLE_BITS'(i_sample);
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

    // Capture when a frame word is taken.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= i_enable ? mag : '0;
        end
    end

    assign o_mag = r_mag;

endmodule

FILE: rtl/wpd_merge.sv
// Merging stage: adds the lane magnitudes into one registered channel sum.
module wpd_merge
    import wpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic [SAMPLE_BITS-1:0] i_mag [MAX_CHANNELS],
    output logic [SUM_BITS-1:0]    o_sum
);

    logic [SUM_BITS-1:0] r_sum;
    logic [SUM_BITS-1:0] acc;

    // Sum of all lanes; unused lanes contribute zero.
    always_comb begin
        acc = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            acc = acc + SUM_BITS'(i_mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= acc;
    end

    assign o_sum = r_sum;

endmodule

FILE: rtl/wpd_div.sv
// Divides the bin's peak channel sum by the channel count through a reciprocal multiply.
module wpd_div
    import wpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic [CH_BITS-1:0]   i_channels,
    input  logic [SUM_BITS-1:0]  i_sum,
    output logic [PEAK_BITS-1:0] o_quot
);

    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    logic [RECIP_BITS-1:0] r_recip;
    logic [PEAK_BITS-1:0]  r_quot;
    logic [PROD_BITS-1:0]  prod;

    // The reciprocal follows the channel count, the quotient follows the sum.
    assign prod = PROD_BITS'(i_sum) * PROD_BITS'(r_recip);

    always_ff @(posedge i_clk) begin
        r_recip <= recip(i_channels);
        r_quot  <= prod[RECIP_SHIFT +: PEAK_BITS];
    end

    assign o_quot = r_quot;

endmodule

FILE: rtl/waveform_peak_decimator_unit.sv
// Top level of the waveform peak decimator: lanes, merge, divider and bin sequencer.
//
// Usage: one frame word (up to eight Q1.15 samples) enters on i_valid/o_ready. The
// lanes take the magnitudes of the first channel_count samples and the merging stage
// adds them. Each bin keeps the largest channel sum it has seen; when a bin closes,
// its peak (the sum divided by the channel count) leaves as one word on
// o_valid/i_ready together with the bin number, a block end flag and a run end flag
// on the last word caused by the frame. Empty bins leave as zero peaks.
// Timing: the sequencer works one frame at a time. A frame passes through the flush,
// fold, wait, flush and end states before the next one is accepted, and stays in a
// flush state while it forms result words. A word moves from the holding stage to
// the output register when the next word is formed; the last word of a run waits
// for the end state, so that its run end flag can be set.
// At most MAX_RUN words follow one frame; bins still due leave with the next frame.
// A stalled receiver holds the sequencer once the output register and the one-word
// holding stage are both full; no word is lost.
// Reset (synchronous, active low) loads channel_count 1, total_frames 1 and
// target_bins 1024 and starts a new block. A write to any register also starts a
// new block; writes are to be made while the block is idle, which it does not enforce.
module waveform_peak_decimator_unit
    import wpd_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_frame                    i_frame,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_result                   o_result,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int COUNT_BITS = $clog2(MAX_RUN + 1);
    localparam logic [COUNT_BITS-1:0] RUN_LIMIT = COUNT_BITS'(MAX_RUN);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FLUSH1 = 6'b000010,
        S_FOLD   = 6'b000100,
        S_WAIT   = 6'b001000,
        S_FLUSH2 = 6'b010000,
        S_END    = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_hold_valid, n_hold_valid;
    t_result               r_hold, n_hold;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;
    logic [CH_BITS-1:0]    r_channel_count, n_channel_count;
    logic [FRAME_BITS-1:0] r_total_frames, n_total_frames;
    logic [BIN_BITS-1:0]   r_target_bins, n_target_bins;
    logic [FRAME_BITS-1:0] r_frame_index, n_frame_index;
    logic [BIN_BITS-1:0]   r_bin_index, n_bin_index;
    logic [BOUND_BITS-1:0] r_bin_bound, n_bin_bound;
    logic [BOUND_BITS-1:0] r_frame_bound, n_frame_bound;
    logic [SUM_BITS-1:0]   r_max_sum, n_max_sum;

    logic [CH_BITS-1:0]     ch_eff;
    logic [FRAME_BITS-1:0]  t_eff;
    logic [BIN_BITS-1:0]    b_eff;
    logic [FRAME_BITS-1:0]  t_eff_next;
    logic [BOUND_BITS:0]    frame_reach;
    logic                   due;
    logic                   last_bin;
    logic                   out_free;
    logic                   emit_ok;
    logic                   restart;
    logic                   load;
    logic                   in_flush;
    logic [SAMPLE_BITS-1:0] samples [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] mags [MAX_CHANNELS];
    logic [SUM_BITS-1:0]    frame_sum;
    logic [PEAK_BITS-1:0]   quot;
    t_result                fresh;

    // Effective register values.
    assign ch_eff     = eff_channels(r_channel_count);
    assign t_eff      = (r_total_frames == '0) ? FRAME_BITS'(1) : r_total_frames;
    assign b_eff      = (r_target_bins == '0) ? BIN_BITS'(1) : r_target_bins;
    assign t_eff_next = (n_total_frames == '0) ? FRAME_BITS'(1) : n_total_frames;

    // A bin closes once its upper bound falls below the frames counted so far.
    assign frame_reach = {1'b0, r_frame_bound} + (BOUND_BITS + 1)'(b_eff);
    assign due         = (r_bin_index < b_eff) && ({1'b0, r_bin_bound} < frame_reach);
    assign last_bin    = ((BIN_BITS + 1)'(r_bin_index) + (BIN_BITS + 1)'(1))
                         == (BIN_BITS + 1)'(b_eff);

    assign out_free = !r_out_valid || i_ready;
    assign emit_ok  = !r_hold_valid || out_free;
    assign load     = i_valid && (r_state == S_IDLE);
    assign in_flush = (r_state == S_FLUSH1) || (r_state == S_FLUSH2);

    // Lanes, one per channel.
    assign samples[0] = SAMPLE_BITS'(i_frame.ch0_sample);
    assign samples[1] = SAMPLE_BITS'(i_frame.ch1_sample);
    assign samples[2] = SAMPLE_BITS'(i_frame.ch2_sample);
    assign samples[3] = SAMPLE_BITS'(i_frame.ch3_sample);
    assign samples[4] = SAMPLE_BITS'(i_frame.ch4_sample);
    assign samples[5] = SAMPLE_BITS'(i_frame.ch5_sample);
    assign samples[6] = SAMPLE_BITS'(i_frame.ch6_sample);
    assign samples[7] = SAMPLE_BITS'(i_frame.ch7_sample);

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
        wpd_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (load),
            .i_enable (CH_BITS'(k) < ch_eff),
            .i_sample (samples[k]),
            .o_mag    (mags[k])
        );
    end

    wpd_merge u_merge (
        .i_clk (i_clk),
        .i_mag (mags),
        .o_sum (frame_sum)
    );

    wpd_div u_div (
        .i_clk      (i_clk),
        .i_channels (ch_eff),
        .i_sum      (r_max_sum),
        .o_quot     (quot)
    );

    // The quotient is registered from the previous peak sum; a zero sum always reads as zero.
    always_comb begin
        fresh.bin_peak   = (r_max_sum == '0) ? '0 : quot;
        fresh.bin_number = r_bin_index;
        fresh.run_end    = 1'b0;
        fresh.block_end  = last_bin;
    end

    // Bin sequencer.
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_hold_valid    = r_hold_valid;
        n_hold          = r_hold;
        n_out_valid     = r_out_valid;
        n_out           = r_out;
        n_channel_count = r_channel_count;
        n_total_frames  = r_total_frames;
        n_target_bins   = r_target_bins;
        n_frame_index   = r_frame_index;
        n_bin_index     = r_bin_index;
        n_bin_bound     = r_bin_bound;
        n_frame_bound   = r_frame_bound;
        n_max_sum       = r_max_sum;
        restart         = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_count = '0;
                    n_state = S_FLUSH1;
                end
            end
            S_FLUSH1, S_FLUSH2: begin
                if (due && (r_count < RUN_LIMIT)) begin
                    if (emit_ok) begin
                        // The previous word moves on; the new one waits in the holding stage
                        // until it is known whether it ends the run.
                        if (r_hold_valid) begin
                            n_out       = r_hold;
                            n_out_valid = 1'b1;
                        end
                        n_hold       = fresh;
                        n_hold_valid = 1'b1;
                        n_count      = r_count + COUNT_BITS'(1);
                        n_max_sum    = '0;
                        n_bin_index  = r_bin_index + BIN_BITS'(1);
                        n_bin_bound  = r_bin_bound + BOUND_BITS'(t_eff);
                        if (last_bin) begin
                            restart = 1'b1;
                            n_state = (r_state == S_FLUSH1) ? S_FOLD : S_END;
                        end
                    end
                end else begin
                    n_state = (r_state == S_FLUSH1) ? S_FOLD : S_END;
                end
            end
            S_FOLD: begin
                // Fold the frame into the open bin and count it if the block has room.
                if (frame_sum > r_max_sum) begin
                    n_max_sum = frame_sum;
                end
                if (r_frame_index < t_eff) begin
                    n_frame_index = r_frame_index + FRAME_BITS'(1);
                    n_frame_bound = r_frame_bound + BOUND_BITS'(b_eff);
                end
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_FLUSH2;
            end
            S_END: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out         = r_hold;
                    n_out.run_end = 1'b1;
                    n_out_valid   = 1'b1;
                    n_hold_valid  = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes restart the block.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: begin
                    n_channel_count = i_cfg_data[CH_BITS-1:0];
                    restart         = 1'b1;
                end
                CFG_TOTAL_FRAMES: begin
                    n_total_frames = i_cfg_data[FRAME_BITS-1:0];
                    restart        = 1'b1;
                end
                CFG_TARGET_BINS: begin
                    n_target_bins = i_cfg_data[BIN_BITS-1:0];
                    restart       = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            n_frame_index = '0;
            n_bin_index   = '0;
            n_bin_bound   = BOUND_BITS'(t_eff_next);
            n_frame_bound = '0;
            n_max_sum     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_hold_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
            r_channel_count <= CH_BITS'(1);
            r_total_frames  <= FRAME_BITS'(1);
            r_target_bins   <= BIN_BITS'(1024);
            r_frame_index   <= '0;
            r_bin_index     <= '0;
            r_bin_bound     <= BOUND_BITS'(1);
            r_frame_bound   <= '0;
            r_max_sum       <= '0;
        end else begin
            r_state         <= n_state;
            r_count         <= n_count;
            r_hold_valid    <= n_hold_valid;
            r_out_valid     <= n_out_valid;
            r_channel_count <= n_channel_count;
            r_total_frames  <= n_total_frames;
            r_target_bins   <= n_target_bins;
            r_frame_index   <= n_frame_index;
            r_bin_index     <= n_bin_index;
            r_bin_bound     <= n_bin_bound;
            r_frame_bound   <= n_frame_bound;
            r_max_sum       <= n_max_sum;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    // A run never exceeds its limit.
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RUN_LIMIT)
        else $error("run counter beyond limit");

    // The holding stage is always drained before the next frame is taken.
    a_hold_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held word left behind at end of step");

    // The open bin always lies inside the block.
    a_bin_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_index < b_eff)
        else $error("bin index past block");

    // A word is formed only in a flush state.
    a_emit_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_hold_valid)) |-> $past(in_flush))
        else $error("word formed outside a flush");
`endif

endmodule
